FILE: design/yrp_pkg.sv
// ----------------------------------------------------------------------------
// yrp_pkg
// Shared types, constants and helpers of the 4:2:2 to RGB pair converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yrp_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int CNT_W         = $clog2(MAX_DIMENSION);
   localparam int DIM_W         = CNT_W + 1;

   localparam int PIXEL_W = 16;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 8;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_STRIDE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_ROWS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd3;

   localparam logic [DIM_W-1:0] RESET_LINE_STRIDE   = 13'd640;
   localparam logic [DIM_W-1:0] RESET_FRAME_ROWS    = 13'd480;
   localparam logic [DIM_W-1:0] RESET_ACTIVE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RESET_ACTIVE_HEIGHT = 13'd480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   // q10 bt.601 coefficients
   localparam int FRAC_W = 10;
   localparam int COEF_W = 13;
   localparam logic signed [COEF_W-1:0] COEF_Y  = 13'sd1192;
   localparam logic signed [COEF_W-1:0] COEF_RV = 13'sd1634;
   localparam logic signed [COEF_W-1:0] COEF_GV = 13'sd833;
   localparam logic signed [COEF_W-1:0] COEF_GU = 13'sd400;
   localparam logic signed [COEF_W-1:0] COEF_BU = 13'sd2066;

   localparam logic signed [BYTE_W:0] LUMA_OFFSET   = 9'sd16;
   localparam logic signed [BYTE_W:0] CHROMA_OFFSET = 9'sd128;

   localparam int PROD_W = 21;
   localparam int SUM_W  = 22;

   typedef struct packed {
      logic [BYTE_W-1:0] luma_first;
      logic [BYTE_W-1:0] luma_second;
      logic [BYTE_W-1:0] blue_chroma;
      logic [BYTE_W-1:0] red_chroma;
      logic [CNT_W-1:0]  pair_row;
      logic [CNT_W-1:0]  pair_column;
      logic              last_pair;
   } yrp_pair_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic floor_one);
      logic [DIM_W-1:0] result;
      begin
         result = value;
         if (value > DIM_W'(MAX_DIMENSION)) begin
            result = DIM_W'(MAX_DIMENSION);
         end else if (floor_one && value == '0) begin
            result = DIM_W'(1);
         end
         return result;
      end
   endfunction

   function automatic logic [COLOR_W-1:0] sat_q10(input logic signed [SUM_W-1:0] sum);
      logic [COLOR_W-1:0] result;
      begin
         if (sum < 0) begin
            result = '0;
         end else if (|sum[SUM_W-2:FRAC_W+COLOR_W]) begin
            result = '1;
         end else begin
            result = sum[FRAC_W+COLOR_W-1:FRAC_W];
         end
         return result;
      end
   endfunction

endpackage

`default_nettype wire

FILE: design/yrp_channels.sv
// ----------------------------------------------------------------------------
// yrp channels
// Valid/ready channels for packed words in and RGB pixel pairs out.
// ----------------------------------------------------------------------------
`default_nettype none

interface yrp_req_if;
   logic                         valid;
   logic                         ready;
   logic [yrp_pkg::PIXEL_W-1:0]  pixel_word;

   modport source (output valid, output pixel_word, input ready);
   modport sink   (input valid, input pixel_word, output ready);
endinterface

interface yrp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [yrp_pkg::COLOR_W-1:0]  red_first;
   logic [yrp_pkg::COLOR_W-1:0]  green_first;
   logic [yrp_pkg::COLOR_W-1:0]  blue_first;
   logic [yrp_pkg::COLOR_W-1:0]  red_second;
   logic [yrp_pkg::COLOR_W-1:0]  green_second;
   logic [yrp_pkg::COLOR_W-1:0]  blue_second;
   logic [yrp_pkg::CNT_W-1:0]    pair_row;
   logic [yrp_pkg::CNT_W-1:0]    pair_column;
   logic                         last_pair;

   modport source (output valid, output red_first, output green_first, output blue_first,
                   output red_second, output green_second, output blue_second,
                   output pair_row, output pair_column, output last_pair, input ready);
   modport sink   (input valid, input red_first, input green_first, input blue_first,
                   input red_second, input green_second, input blue_second,
                   input pair_row, input pair_column, input last_pair, output ready);
endinterface

`default_nettype wire

FILE: design/ycbcr422_to_rgb_pairs_unit.sv
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb_pairs_unit
// Packed 4:2:2 YCbCr raster stream to BT.601 RGB pixel pairs.
// ----------------------------------------------------------------------------
// Takes one packed word per cycle while the queue has room (luma in the low
// byte, Cb or Cr in the high byte) and returns one RGB pair for every odd
// active column, tagged with row, column and a last-of-frame flag. A pair
// reaches the response by this path: the tracking front writes a four-entry
// queue, then a product stage and a sum/saturate stage fill the response
// register. The front keeps taking requests while the queue has room, so a
// stalled response side holds back the request side only after six pairs
// are waiting: four in the queue and one in each conversion stage. Registers
// take effect on the next request; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ycbcr422_to_rgb_pairs_unit (
   input  logic                          clock,
   input  logic                          reset,
   yrp_req_if.sink                       req_bus,
   yrp_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [yrp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [yrp_pkg::DIM_W-1:0]     csr_write_data
);

   logic                  push, pop, queue_full, head_valid;
   yrp_pkg::yrp_pair_type push_pair, head_pair;

   yrp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .pair             (push_pair)
   );

   yrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_pair  (push_pair),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_pair  (head_pair)
   );

   yrp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pair  (head_pair),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: design/yrp_front.sv
// ----------------------------------------------------------------------------
// yrp_front
// Raster tracking: counts columns and rows, drops words outside the active
// area, holds even words and queues a pair for every odd word.
// ----------------------------------------------------------------------------
`default_nettype none

module yrp_front (
   input  logic                             clock,
   input  logic                             reset,
   yrp_req_if.sink                          req_bus,
   input  logic                             csr_write_enable,
   input  logic [yrp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [yrp_pkg::DIM_W-1:0]        csr_write_data,
   input  logic                             queue_full,
   output logic                             push,
   output yrp_pkg::yrp_pair_type            pair
);

   logic [yrp_pkg::DIM_W-1:0]  line_stride_ff, line_stride_in;
   logic [yrp_pkg::DIM_W-1:0]  frame_rows_ff, frame_rows_in;
   logic [yrp_pkg::DIM_W-1:0]  active_width_ff, active_width_in;
   logic [yrp_pkg::DIM_W-1:0]  active_height_ff, active_height_in;
   logic [yrp_pkg::CNT_W-1:0]  column_ff, column_in;
   logic [yrp_pkg::CNT_W-1:0]  row_ff, row_in;
   logic [yrp_pkg::BYTE_W-1:0] held_luma_ff, held_luma_in;
   logic [yrp_pkg::BYTE_W-1:0] held_blue_ff, held_blue_in;

   logic [yrp_pkg::DIM_W-1:0]  stride, rows, width_lim, height_lim, act_w, act_h;
   logic [yrp_pkg::DIM_W-1:0]  column_next, column_plus_two, row_next;
   logic [yrp_pkg::BYTE_W-1:0] luma, chroma;
   logic                       accept, in_area;

   assign req_bus.ready = !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign luma          = req_bus.pixel_word[yrp_pkg::BYTE_W-1:0];
   assign chroma        = req_bus.pixel_word[yrp_pkg::PIXEL_W-1:yrp_pkg::BYTE_W];

   always_comb begin
      stride     = yrp_pkg::clamp_dim(line_stride_ff, 1'b1);
      rows       = yrp_pkg::clamp_dim(frame_rows_ff, 1'b1);
      act_w      = yrp_pkg::clamp_dim(active_width_ff, 1'b0);
      act_h      = yrp_pkg::clamp_dim(active_height_ff, 1'b0);
      width_lim  = (act_w < stride) ? act_w : stride;
      height_lim = (act_h < rows) ? act_h : rows;
   end

   assign column_next     = {1'b0, column_ff} + yrp_pkg::DIM_W'(1);
   assign column_plus_two = {1'b0, column_ff} + yrp_pkg::DIM_W'(2);
   assign row_next        = {1'b0, row_ff} + yrp_pkg::DIM_W'(1);
   assign in_area = ({1'b0, row_ff} < height_lim) && ({1'b0, column_ff} < width_lim);

   always_comb begin
      line_stride_in   = line_stride_ff;
      frame_rows_in    = frame_rows_ff;
      active_width_in  = active_width_ff;
      active_height_in = active_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            yrp_pkg::REG_LINE_STRIDE:   line_stride_in   = csr_write_data;
            yrp_pkg::REG_FRAME_ROWS:    frame_rows_in    = csr_write_data;
            yrp_pkg::REG_ACTIVE_WIDTH:  active_width_in  = csr_write_data;
            yrp_pkg::REG_ACTIVE_HEIGHT: active_height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      held_luma_in = held_luma_ff;
      held_blue_in = held_blue_ff;
      if (accept) begin
         if (in_area && !column_ff[0]) begin
            held_luma_in = luma;
            held_blue_in = chroma;
         end
         if (column_next >= stride) begin
            column_in = '0;
            row_in    = (row_next >= rows) ? '0 : row_next[yrp_pkg::CNT_W-1:0];
         end else begin
            column_in = column_next[yrp_pkg::CNT_W-1:0];
         end
      end
   end

   always_comb begin
      push             = accept && in_area && column_ff[0];
      pair.luma_first  = held_luma_ff;
      pair.luma_second = luma;
      pair.blue_chroma = held_blue_ff;
      pair.red_chroma  = chroma;
      pair.pair_row    = row_ff;
      pair.pair_column = column_ff - yrp_pkg::CNT_W'(1);
      pair.last_pair   = (column_plus_two >= width_lim) && (row_next >= height_lim);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_stride_ff   <= yrp_pkg::RESET_LINE_STRIDE;
         frame_rows_ff    <= yrp_pkg::RESET_FRAME_ROWS;
         active_width_ff  <= yrp_pkg::RESET_ACTIVE_WIDTH;
         active_height_ff <= yrp_pkg::RESET_ACTIVE_HEIGHT;
         column_ff        <= '0;
         row_ff           <= '0;
         held_luma_ff     <= '0;
         held_blue_ff     <= '0;
      end else begin
         line_stride_ff   <= line_stride_in;
         frame_rows_ff    <= frame_rows_in;
         active_width_ff  <= active_width_in;
         active_height_ff <= active_height_in;
         column_ff        <= column_in;
         row_ff           <= row_in;
         held_luma_ff     <= held_luma_in;
         held_blue_ff     <= held_blue_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/yrp_queue.sv
// ----------------------------------------------------------------------------
// yrp_queue
// Short first-in first-out buffer of pixel pairs between tracking and
// color conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module yrp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  yrp_pkg::yrp_pair_type push_pair,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output yrp_pkg::yrp_pair_type head_pair
);

   yrp_pkg::yrp_pair_type            entry_ff [yrp_pkg::QUEUE_DEPTH];
   logic [yrp_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [yrp_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [yrp_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                             do_pop;

   assign full       = (count_ff == yrp_pkg::QUEUE_CNT_W'(yrp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_pair  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + yrp_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + yrp_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + yrp_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - yrp_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/yrp_back.sv
// ----------------------------------------------------------------------------
// yrp_back
// Two-stage color conversion: q10 coefficient products, then sums with
// saturation into the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module yrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  yrp_pkg::yrp_pair_type head_pair,
   output logic                  pop,
   yrp_rsp_if.source             rsp_bus
);

   localparam int PW = yrp_pkg::PROD_W;
   localparam int SW = yrp_pkg::SUM_W;

   logic                      advance;

   logic signed [yrp_pkg::BYTE_W:0] y1_off, y2_off, u_off, v_off;
   logic signed [PW-1:0]            y1_ext, y2_ext, u_ext, v_ext;
   logic signed [PW-1:0]            coef_y, coef_rv, coef_gv, coef_gu, coef_bu;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [PW-1:0]      yy1_ff, yy2_ff, rv_ff, gv_ff, gu_ff, bu_ff;
   logic [yrp_pkg::CNT_W-1:0] s1_row_ff, s1_column_ff;
   logic                      s1_last_ff;

   logic signed [SW-1:0]      yy1_s, yy2_s, rv_s, gv_s, gu_s, bu_s;
   logic signed [SW-1:0]      r1_sum, g1_sum, b1_sum, r2_sum, g2_sum, b2_sum;

   logic                         out_valid_ff, out_valid_in;
   logic [yrp_pkg::COLOR_W-1:0]  red1_ff, green1_ff, blue1_ff;
   logic [yrp_pkg::COLOR_W-1:0]  red2_ff, green2_ff, blue2_ff;
   logic [yrp_pkg::CNT_W-1:0]    row_ff, column_ff;
   logic                         last_ff;

   assign advance = !out_valid_ff || rsp_bus.ready;
   assign pop     = advance && head_valid;

   always_comb begin
      y1_off  = $signed({1'b0, head_pair.luma_first}) - yrp_pkg::LUMA_OFFSET;
      y2_off  = $signed({1'b0, head_pair.luma_second}) - yrp_pkg::LUMA_OFFSET;
      u_off   = $signed({1'b0, head_pair.blue_chroma}) - yrp_pkg::CHROMA_OFFSET;
      v_off   = $signed({1'b0, head_pair.red_chroma}) - yrp_pkg::CHROMA_OFFSET;
      y1_ext  = PW'(y1_off);
      y2_ext  = PW'(y2_off);
      u_ext   = PW'(u_off);
      v_ext   = PW'(v_off);
      coef_y  = PW'(yrp_pkg::COEF_Y);
      coef_rv = PW'(yrp_pkg::COEF_RV);
      coef_gv = PW'(yrp_pkg::COEF_GV);
      coef_gu = PW'(yrp_pkg::COEF_GU);
      coef_bu = PW'(yrp_pkg::COEF_BU);
   end

   assign s1_valid_in  = advance ? head_valid : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (advance) begin
         yy1_ff       <= coef_y * y1_ext;
         yy2_ff       <= coef_y * y2_ext;
         rv_ff        <= coef_rv * v_ext;
         gv_ff        <= coef_gv * v_ext;
         gu_ff        <= coef_gu * u_ext;
         bu_ff        <= coef_bu * u_ext;
         s1_row_ff    <= head_pair.pair_row;
         s1_column_ff <= head_pair.pair_column;
         s1_last_ff   <= head_pair.last_pair;
      end
   end

   always_comb begin
      yy1_s  = SW'(yy1_ff);
      yy2_s  = SW'(yy2_ff);
      rv_s   = SW'(rv_ff);
      gv_s   = SW'(gv_ff);
      gu_s   = SW'(gu_ff);
      bu_s   = SW'(bu_ff);
      r1_sum = yy1_s + rv_s;
      g1_sum = yy1_s - gv_s - gu_s;
      b1_sum = yy1_s + bu_s;
      r2_sum = yy2_s + rv_s;
      g2_sum = yy2_s - gv_s - gu_s;
      b2_sum = yy2_s + bu_s;
   end

   // stage 2: sums and saturation
   always_ff @(posedge clock) begin
      if (advance) begin
         red1_ff   <= yrp_pkg::sat_q10(r1_sum);
         green1_ff <= yrp_pkg::sat_q10(g1_sum);
         blue1_ff  <= yrp_pkg::sat_q10(b1_sum);
         red2_ff   <= yrp_pkg::sat_q10(r2_sum);
         green2_ff <= yrp_pkg::sat_q10(g2_sum);
         blue2_ff  <= yrp_pkg::sat_q10(b2_sum);
         row_ff    <= s1_row_ff;
         column_ff <= s1_column_ff;
         last_ff   <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.red_first    = red1_ff;
   assign rsp_bus.green_first  = green1_ff;
   assign rsp_bus.blue_first   = blue1_ff;
   assign rsp_bus.red_second   = red2_ff;
   assign rsp_bus.green_second = green2_ff;
   assign rsp_bus.blue_second  = blue2_ff;
   assign rsp_bus.pair_row     = row_ff;
   assign rsp_bus.pair_column  = column_ff;
   assign rsp_bus.last_pair    = last_ff;

endmodule

`default_nettype wire

FILE: design/yrp_checker.sv
// ----------------------------------------------------------------------------
// yrp_checker
// Port-level checks of the pixel pair converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yrp_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [yrp_pkg::CNT_W-1:0]   rsp_pair_row,
   input  logic [yrp_pkg::CNT_W-1:0]   rsp_pair_column,
   input  logic                        rsp_last_pair
);

   // response channel empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn while stalled");

   // stalled response keeps its position and flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pair_row) && $stable(rsp_pair_column)
                                  && $stable(rsp_last_pair))
      else $error("response changed while stalled");

   // a pair always starts on an even column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pair_column[0])
      else $error("pair column is odd");

endmodule

bind ycbcr422_to_rgb_pairs_unit yrp_checker u_yrp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_pair_row    (rsp_bus.pair_row),
   .rsp_pair_column (rsp_bus.pair_column),
   .rsp_last_pair   (rsp_bus.last_pair)
);

`default_nettype wire

FILE: tb/ycbcr422_to_rgb_pairs_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb_pairs_unit_tb
// Self-checking regression of the 4:2:2 to RGB pair converter. A raster
// tracker in the bench follows every accepted request, works out the BT.601
// pair it must produce and queues it. Each returned pair is checked against
// the oldest queued one. Directed extremes and frame edge cases come first,
// then a wide line, a tall frame and random rasters under random idling.
// ----------------------------------------------------------------------------

module ycbcr422_to_rgb_pairs_unit_tb;

   localparam int GAIN_Y       = 1192;
   localparam int GAIN_RED_V   = 1634;
   localparam int GAIN_GREEN_V = 833;
   localparam int GAIN_GREEN_U = 400;
   localparam int GAIN_BLUE_U  = 2066;

   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;
   localparam int RESET_CYCLES  = 11;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [yrp_pkg::COLOR_W-1:0] red;
      logic [yrp_pkg::COLOR_W-1:0] green;
      logic [yrp_pkg::COLOR_W-1:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic [yrp_pkg::COLOR_W-1:0] red_first;
      logic [yrp_pkg::COLOR_W-1:0] green_first;
      logic [yrp_pkg::COLOR_W-1:0] blue_first;
      logic [yrp_pkg::COLOR_W-1:0] red_second;
      logic [yrp_pkg::COLOR_W-1:0] green_second;
      logic [yrp_pkg::COLOR_W-1:0] blue_second;
      logic [yrp_pkg::CNT_W-1:0]   pair_row;
      logic [yrp_pkg::CNT_W-1:0]   pair_column;
      logic                        last_pair;
   } rgb_pair_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_enable;
   logic [yrp_pkg::CSR_IDX_W-1:0] csr_index;
   logic [yrp_pkg::DIM_W-1:0]     csr_write_data;

   yrp_req_if req_bus ();
   yrp_rsp_if rsp_bus ();

   ycbcr422_to_rgb_pairs_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // raster tracker state
   logic [yrp_pkg::DIM_W-1:0]  stride_reg;
   logic [yrp_pkg::DIM_W-1:0]  rows_reg;
   logic [yrp_pkg::DIM_W-1:0]  width_reg;
   logic [yrp_pkg::DIM_W-1:0]  height_reg;
   int unsigned                column_pos;
   int unsigned                row_pos;
   logic [yrp_pkg::BYTE_W-1:0] held_luma;
   logic [yrp_pkg::BYTE_W-1:0] held_cb;

   rgb_pair_type pending_pairs[$];
   int unsigned  send_idle_pct;
   int unsigned  rsp_stall_pct;
   int unsigned  mismatch_count = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("ycbcr422_to_rgb_pairs_unit regression: fail");
      $finish;
   end

   function automatic logic [yrp_pkg::COLOR_W-1:0] saturate_q10(input int sum);
      int scaled;
      if (sum < 0) return '0;
      scaled = sum >>> 10;
      if (scaled > 255) return '1;
      return scaled[yrp_pkg::COLOR_W-1:0];
   endfunction

   function automatic rgb_pixel_type bt601_pixel(input logic [yrp_pkg::BYTE_W-1:0] luma,
                                                 input logic [yrp_pkg::BYTE_W-1:0] cb,
                                                 input logic [yrp_pkg::BYTE_W-1:0] cr);
      int            yy;
      int            u;
      int            v;
      rgb_pixel_type px;
      yy = GAIN_Y * (int'(luma) - 16);
      u = int'(cb) - 128;
      v = int'(cr) - 128;
      px.red = saturate_q10(yy + GAIN_RED_V * v);
      px.green = saturate_q10(yy - GAIN_GREEN_V * v - GAIN_GREEN_U * u);
      px.blue = saturate_q10(yy + GAIN_BLUE_U * u);
      return px;
   endfunction

   function automatic int unsigned limit_dimension(input logic [yrp_pkg::DIM_W-1:0] value,
                                                   input int unsigned floor_value);
      if (value < floor_value) return floor_value;
      if (value > yrp_pkg::MAX_DIMENSION) return yrp_pkg::MAX_DIMENSION;
      return 32'(value);
   endfunction

   function automatic void track_word(input logic [yrp_pkg::PIXEL_W-1:0] word);
      int unsigned   stride;
      int unsigned   rows;
      int unsigned   w;
      int unsigned   h;
      rgb_pixel_type first_px;
      rgb_pixel_type second_px;
      rgb_pair_type  pair;
      stride = limit_dimension(stride_reg, 1);
      rows = limit_dimension(rows_reg, 1);
      w = limit_dimension(width_reg, 0);
      h = limit_dimension(height_reg, 0);
      if (stride < w) w = stride;
      if (rows < h) h = rows;
      if (row_pos < h && column_pos < w) begin
         if (column_pos[0] == 1'b0) begin
            held_luma = word[yrp_pkg::BYTE_W-1:0];
            held_cb = word[yrp_pkg::PIXEL_W-1:yrp_pkg::BYTE_W];
         end else begin
            first_px = bt601_pixel(held_luma, held_cb,
                                   word[yrp_pkg::PIXEL_W-1:yrp_pkg::BYTE_W]);
            second_px = bt601_pixel(word[yrp_pkg::BYTE_W-1:0], held_cb,
                                    word[yrp_pkg::PIXEL_W-1:yrp_pkg::BYTE_W]);
            pair.red_first = first_px.red;
            pair.green_first = first_px.green;
            pair.blue_first = first_px.blue;
            pair.red_second = second_px.red;
            pair.green_second = second_px.green;
            pair.blue_second = second_px.blue;
            pair.pair_row = yrp_pkg::CNT_W'(row_pos);
            pair.pair_column = yrp_pkg::CNT_W'(column_pos - 1);
            pair.last_pair = (column_pos + 2 >= w) && (row_pos + 1 >= h);
            pending_pairs.push_back(pair);
         end
      end
      if (column_pos + 1 >= stride) begin
         column_pos = 0;
         row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
         column_pos = column_pos + 1;
      end
   endfunction

   function automatic string pair_text(input rgb_pair_type p);
      return $sformatf("row %0d col %0d last %0b rgb %02h%02h%02h %02h%02h%02h",
                       p.pair_row, p.pair_column, p.last_pair, p.red_first,
                       p.green_first, p.blue_first, p.red_second, p.green_second,
                       p.blue_second);
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
   endfunction

   function automatic void set_idling(input idle_mode_type mode);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      case (mode)
         IDLE_SENDER: begin
            send_idle_pct = 66;
         end
         IDLE_RECEIVER: begin
            rsp_stall_pct = 66;
         end
         IDLE_BOTH: begin
            send_idle_pct = 19;
            rsp_stall_pct = 19;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [yrp_pkg::BYTE_W-1:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h10;
         3: return 8'h80;
         default: return yrp_pkg::BYTE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [yrp_pkg::PIXEL_W-1:0] random_word();
      return {pick_byte(), pick_byte()};
   endfunction

   function automatic logic [yrp_pkg::DIM_W-1:0] pick_dimension(input int unsigned low,
                                                                input int unsigned high);
      case ($urandom_range(19))
         0: return '0;
         1: return yrp_pkg::DIM_W'($urandom_range(8191));
         2: return yrp_pkg::DIM_W'(yrp_pkg::MAX_DIMENSION + $urandom_range(4095));
         default: return yrp_pkg::DIM_W'($urandom_range(high, low));
      endcase
   endfunction

   // response side stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // pair checker
   always @(posedge clock) begin
      rgb_pair_type seen;
      rgb_pair_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.red_first = rsp_bus.red_first;
         seen.green_first = rsp_bus.green_first;
         seen.blue_first = rsp_bus.blue_first;
         seen.red_second = rsp_bus.red_second;
         seen.green_second = rsp_bus.green_second;
         seen.blue_second = rsp_bus.blue_second;
         seen.pair_row = rsp_bus.pair_row;
         seen.pair_column = rsp_bus.pair_column;
         seen.last_pair = rsp_bus.last_pair;
         if (pending_pairs.size() == 0) begin
            note_mismatch({"unexpected pair ", pair_text(seen)});
         end else begin
            want = pending_pairs.pop_front();
            if (seen !== want) begin
               note_mismatch({"expected ", pair_text(want), " got ", pair_text(seen)});
            end
         end
      end
   end

   task automatic send_word(input logic [yrp_pkg::PIXEL_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_word <= word;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_word(word);
   endtask

   task automatic drain_pairs();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_pairs.size() != 0);
   endtask

   task automatic set_frame(input logic [yrp_pkg::DIM_W-1:0] stride,
                            input logic [yrp_pkg::DIM_W-1:0] rows,
                            input logic [yrp_pkg::DIM_W-1:0] width,
                            input logic [yrp_pkg::DIM_W-1:0] height);
      logic [yrp_pkg::DIM_W-1:0]     values[4];
      logic [yrp_pkg::CSR_IDX_W-1:0] order[4];
      drain_pairs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      values = '{stride, rows, width, height};
      order = '{yrp_pkg::REG_LINE_STRIDE, yrp_pkg::REG_FRAME_ROWS,
                yrp_pkg::REG_ACTIVE_WIDTH, yrp_pkg::REG_ACTIVE_HEIGHT};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= order[i];
         csr_write_data <= values[i];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      stride_reg = stride;
      rows_reg = rows;
      width_reg = width;
      height_reg = height;
   endtask

   // one word with a one-by-one raster puts both counters back to zero
   task automatic rewind_raster();
      set_frame(13'd1, 13'd1, 13'd0, 13'd0);
      send_word(random_word());
   endtask

   task automatic test_conversion_extremes();
      logic [yrp_pkg::PIXEL_W-1:0] words[8];
      set_idling(IDLE_NONE);
      words = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                16'h80EB, 16'h8010, 16'h10FF, 16'hF0FF};
      foreach (words[i]) send_word(words[i]);
   endtask

   task automatic test_frame_edges();
      set_idling(IDLE_BOTH);
      // odd active width: last even column held, never emitted
      rewind_raster();
      set_frame(13'd3, 13'd2, 13'd3, 13'd2);
      repeat (6) send_word(random_word());
      // active area wider than the line
      rewind_raster();
      set_frame(13'd2, 13'd2, 13'd6, 13'd5);
      repeat (4) send_word(random_word());
      // too narrow for a pair
      set_frame(13'd4, 13'd1, 13'd1, 13'd1);
      repeat (4) send_word(random_word());
      // zero height and zero stride
      set_frame(13'd0, 13'd3, 13'd4, 13'd0);
      repeat (4) send_word(random_word());
   endtask

   task automatic test_wide_line();
      set_idling(IDLE_BOTH);
      rewind_raster();
      set_frame(13'd8191, 13'd0, 13'd8191, 13'd8191);
      repeat (32) send_word(random_word());
   endtask

   task automatic test_tall_frame();
      set_idling(IDLE_NONE);
      rewind_raster();
      set_frame(13'd2, 13'd8191, 13'd2, 13'd4096);
      repeat (40) send_word(random_word());
   endtask

   task automatic test_random_rasters();
      for (int phase = 0; phase < 8; phase++) begin
         set_frame(pick_dimension(1, 12), pick_dimension(1, 6),
                   pick_dimension(0, 14), pick_dimension(0, 7));
         set_idling(idle_mode_type'(phase % 4));
         for (int n = 0; n < 48; n++) begin
            if ($urandom_range(49) == 0) drain_pairs();
            send_word(random_word());
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= yrp_pkg::REG_LINE_STRIDE;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.pixel_word <= '0;
      stride_reg = yrp_pkg::RESET_LINE_STRIDE;
      rows_reg = yrp_pkg::RESET_FRAME_ROWS;
      width_reg = yrp_pkg::RESET_ACTIVE_WIDTH;
      height_reg = yrp_pkg::RESET_ACTIVE_HEIGHT;
      column_pos = 0;
      row_pos = 0;
      held_luma = '0;
      held_cb = '0;
      set_idling(IDLE_NONE);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_conversion_extremes();
      test_frame_edges();
      test_wide_line();
      test_tall_frame();
      test_random_rasters();

      drain_pairs();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (pending_pairs.size() != 0) note_mismatch("pairs never returned");
      if (mismatch_count == 0) begin
         $display("ycbcr422_to_rgb_pairs_unit regression: pass");
      end else begin
         $display("ycbcr422_to_rgb_pairs_unit regression: fail");
      end
      $finish;
   end

endmodule
